// ----- hw/rtl/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types, widths and codes for the double-ended stack allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 21;
   localparam int KIND_W   = 3;
   localparam int STAT_W   = 2;
   localparam int CSR_IDX_W = 1;
   localparam int DIVD_W   = ADDR_W + 1;
   localparam int CNT_W    = $clog2(DIVD_W + 1);

   localparam logic [SIZE_W-1:0] REGION_RESET = SIZE_W'(1048576);

   localparam logic [KIND_W-1:0] KIND_ALLOC_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FREE_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FREE_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR_ALL   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CLEAR_FRONT = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CLEAR_BACK  = 3'd6;

   localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_SPACE   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BAD_MARKER = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_SIZE  = 1'd1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SIZE_W-1:0] size_bytes;
      logic [SIZE_W-1:0] alignment;
      logic [SIZE_W-1:0] marker;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] front_used;
      logic [SIZE_W-1:0] back_used;
      logic [SIZE_W-1:0] free_bytes;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic launch;
      logic exec;
   } dp_cmd_type;

   typedef struct packed {
      logic req_alloc;
      logic early_fail;
      logic div_busy;
   } dp_stat_type;

endpackage

// ----- hw/rtl/dsa_rem.sv -----
// ----------------------------------------------------------------------------
// dsa_rem
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module dsa_rem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [dsa_pkg::DIVD_W-1:0] dividend,
   input  logic [dsa_pkg::SIZE_W-1:0] divisor,
   output logic                       busy,
   output logic [dsa_pkg::SIZE_W-1:0] remainder
);
   import dsa_pkg::*;

   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] div_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [SIZE_W:0]   shifted;
   logic [SIZE_W+1:0] diff;

   assign shifted = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         rem_in = diff[SIZE_W+1] ? shifted[SIZE_W-1:0] : diff[SIZE_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

`ifndef ASSERT_OFF
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> div_ff != '0) else $error("zero divisor in remainder unit");
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < div_ff) else $error("partial remainder not reduced");
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("busy with empty bit count");
`endif

endmodule

// ----- hw/rtl/dsa_dp.sv -----
// ----------------------------------------------------------------------------
// dsa_dp
// Datapath: config registers, markers, request latch, remainder unit and
// result register.
// ----------------------------------------------------------------------------
module dsa_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [dsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dsa_pkg::ADDR_W-1:0]    csr_wdata,
   input  dsa_pkg::req_type              req_payload,
   input  dsa_pkg::dp_cmd_type           cmd,
   output dsa_pkg::dp_stat_type          stat,
   output dsa_pkg::rsp_type              rsp_payload
);
   import dsa_pkg::*;

   function automatic logic [SIZE_W-1:0] sat_sub(input logic [SIZE_W-1:0] a,
                                                 input logic [SIZE_W:0]   b);
      logic [SIZE_W-1:0] r;
      r = '0;
      if ({1'b0, a} > b) begin
         r = a - b[SIZE_W-1:0];
      end
      return r;
   endfunction

   logic [ADDR_W-1:0] base_ff;
   logic [SIZE_W-1:0] region_ff;
   logic [SIZE_W-1:0] front_ff, front_in;
   logic [SIZE_W-1:0] back_ff, back_in;

   logic [KIND_W-1:0] kind_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] align_ff;
   logic [SIZE_W-1:0] marker_ff;

   logic [DIVD_W-1:0] dividend_ff, dividend_in;
   logic [SIZE_W:0]   need_ff, need_in;
   logic [SIZE_W-1:0] limit_ff, limit_in;
   logic              fail_ff, fail_in;

   logic [SIZE_W-1:0] sat_front;
   logic [SIZE_W-1:0] sat_back;
   logic              div_busy;
   logic [SIZE_W-1:0] rem;
   logic [SIZE_W-1:0] pad;
   logic [SIZE_W-1:0] addend;
   logic [SIZE_W+1:0] total;
   logic              alloc_ok;
   logic [SIZE_W:0]   used_sum;
   rsp_type           rsp_ff, rsp_in;

   assign sat_front = sat_sub(region_ff, {1'b0, front_ff});
   assign sat_back  = sat_sub(region_ff, {1'b0, back_ff});

   // setup for the alignment remainder
   always_comb begin
      if (kind_ff == KIND_ALLOC_FRONT) begin
         dividend_in = {1'b0, base_ff} + DIVD_W'(front_ff);
         need_in     = {1'b0, front_ff} + {1'b0, size_ff};
         limit_in    = sat_back;
      end else begin
         dividend_in = {1'b0, base_ff} + DIVD_W'(region_ff) - DIVD_W'(back_ff)
                       - DIVD_W'(size_ff);
         need_in     = {1'b0, back_ff} + {1'b0, size_ff};
         limit_in    = sat_front;
      end
      fail_in = (kind_ff != KIND_ALLOC_FRONT) && (need_in > {1'b0, limit_in});
   end

   dsa_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.launch),
      .dividend  (dividend_ff),
      .divisor   (align_ff),
      .busy      (div_busy),
      .remainder (rem)
   );

   assign pad      = (rem == '0) ? '0 : align_ff - rem;
   assign addend   = (kind_ff == KIND_ALLOC_FRONT) ? pad : rem;
   assign total    = {1'b0, need_ff} + {2'b00, addend};
   assign alloc_ok = !fail_ff && (total <= {2'b00, limit_ff});

   always_comb begin
      front_in       = front_ff;
      back_in        = back_ff;
      rsp_in.status  = STATUS_OK;
      rsp_in.address = '0;
      case (kind_ff)
         KIND_ALLOC_FRONT: begin
            if (alloc_ok) begin
               front_in       = total[SIZE_W-1:0];
               rsp_in.address = dividend_ff[ADDR_W-1:0] + ADDR_W'(pad);
            end else begin
               rsp_in.status = STATUS_NO_SPACE;
            end
         end
         KIND_ALLOC_BACK: begin
            if (alloc_ok) begin
               back_in        = total[SIZE_W-1:0];
               rsp_in.address = dividend_ff[ADDR_W-1:0] - ADDR_W'(rem);
            end else begin
               rsp_in.status = STATUS_NO_SPACE;
            end
         end
         KIND_FREE_FRONT: begin
            if (marker_ff <= sat_back) begin
               front_in = marker_ff;
            end else begin
               rsp_in.status = STATUS_BAD_MARKER;
            end
         end
         KIND_FREE_BACK: begin
            if (marker_ff <= sat_front) begin
               back_in = marker_ff;
            end else begin
               rsp_in.status = STATUS_BAD_MARKER;
            end
         end
         KIND_CLEAR_ALL: begin
            front_in = '0;
            back_in  = '0;
         end
         KIND_CLEAR_FRONT: begin
            front_in = '0;
         end
         KIND_CLEAR_BACK: begin
            back_in = '0;
         end
         default: begin
         end
      endcase
      used_sum          = {1'b0, front_in} + {1'b0, back_in};
      rsp_in.front_used = front_in;
      rsp_in.back_used  = back_in;
      rsp_in.free_bytes = sat_sub(region_ff, used_sum);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_payload.kind;
         size_ff   <= req_payload.size_bytes;
         align_ff  <= (req_payload.alignment == '0) ? SIZE_W'(1) : req_payload.alignment;
         marker_ff <= req_payload.marker;
      end
      if (cmd.prep) begin
         dividend_ff <= dividend_in;
         need_ff     <= need_in;
         limit_ff    <= limit_in;
         fail_ff     <= fail_in;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         base_ff   <= '0;
         region_ff <= REGION_RESET;
         front_ff  <= '0;
         back_ff   <= '0;
      end else begin
         if (csr_wr_en && csr_index == CSR_BASE_ADDRESS) begin
            base_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == CSR_REGION_SIZE) begin
            region_ff <= csr_wdata[SIZE_W-1:0];
         end
         if (cmd.exec) begin
            front_ff <= front_in;
            back_ff  <= back_in;
         end
      end
   end

   assign stat.req_alloc  = (req_payload.kind == KIND_ALLOC_FRONT) ||
                            (req_payload.kind == KIND_ALLOC_BACK);
   assign stat.early_fail = fail_ff;
   assign stat.div_busy   = div_busy;
   assign rsp_payload     = rsp_ff;

`ifndef ASSERT_OFF
   a_front_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && kind_ff == KIND_ALLOC_FRONT && alloc_ok
      |-> front_in <= sat_back)
      else $error("front allocation overlaps back end");
   a_back_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && kind_ff == KIND_ALLOC_BACK && alloc_ok
      |-> back_in <= sat_front)
      else $error("back allocation overlaps front end");
   a_exec_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !div_busy) else $error("result taken while remainder busy");
`endif

endmodule

// ----- hw/rtl/dsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsa_ctrl
// Controller: sequences one request through setup, remainder and update as
// its kind needs, and owns the result valid flag.
// ----------------------------------------------------------------------------
module dsa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  dsa_pkg::dp_stat_type   stat,
   output dsa_pkg::dp_cmd_type    cmd
);
   import dsa_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PREP   = 5'b00010,
      ST_LAUNCH = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_EXEC   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.req_alloc ? ST_PREP : ST_EXEC;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            if (stat.early_fail) begin
               state_in = ST_EXEC;
            end else begin
               cmd.launch = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!stat.div_busy) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (rsp_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.exec || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending result overwritten");
   a_launch_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.launch |=> stat.div_busy) else $error("remainder unit did not start");
   a_div_to_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && !stat.div_busy |=> state_ff == ST_EXEC)
      else $error("missed remainder completion");
`endif

endmodule

// ----- hw/rtl/double_ended_stack_allocator.sv -----
// ----------------------------------------------------------------------------
// double_ended_stack_allocator
// Two-ended byte allocator over one region with aligned allocations.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   dsa_pkg::req_type
// rsp       out        rsp_valid/rsp_stall   dsa_pkg::rsp_type
// csr       in         csr_wr_en             csr_index, csr_wdata
//
// Allocations register their result after setup, launch, the bit-serial
// alignment remainder over all 33 dividend bits, a step to see it idle, and
// update; the next request is taken in the cycle after the update. Back
// allocations that do not fit skip the remainder. Frees, clears and unused
// kinds go straight to update. Update waits while a held result is stalled.
// One request at a time; a new request is taken while a result waits.
// Reset is synchronous; markers clear and region_size returns to 1 MiB.
// ----------------------------------------------------------------------------
module double_ended_stack_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dsa_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dsa_pkg::rsp_type              rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [dsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dsa_pkg::ADDR_W-1:0]    csr_wdata
);
   import dsa_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   dsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dsa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule
